[rtl/ccst_pkg.sv]
// package: date types, calendar constants and leap-year helpers for the clock
`timescale 1ns / 1ps
`default_nettype none
package ccst_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_LOAD = 2'd1,
        MODE_CMP  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_date;

    typedef struct packed {
        logic is_equal;
        logic is_later;
        logic is_earlier;
    } t_flags;

    localparam logic [YEAR_W-1:0] MAX_YEAR   = 14'd9999;
    localparam logic [YEAR_W-1:0] RST_YEAR   = 14'd2000;
    localparam logic [MON_W-1:0]  MONTHS     = 4'd12;
    localparam logic [DAY_W-1:0]  DAYS_LONG  = 5'd31;
    localparam logic [DAY_W-1:0]  DAYS_SHORT = 5'd30;
    localparam logic [DAY_W-1:0]  DAYS_FEB   = 5'd28;
    localparam logic [DAY_W-1:0]  DAYS_FEB_L = 5'd29;
    localparam logic [HOUR_W-1:0] LAST_HOUR  = 5'd23;
    localparam logic [MIN_W-1:0]  LAST_MIN   = 6'd59;
    localparam logic [SEC_W-1:0]  LAST_SEC   = 6'd59;

    localparam t_date RST_DATE = '{
        year: RST_YEAR, month: 4'd1, day: 5'd1,
        hour: 5'd0, minute: 6'd0, second: 6'd0
    };

    // reciprocal of 100 scaled by 2^19, exact for years up to 9999
    localparam int            RECIP_SHIFT = 19;
    localparam int            PROD_W      = 27;
    localparam logic [12:0]   RECIP_100   = 13'd5243;

    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] p;
        logic              div100;
        logic [1:0]        q_lo;
        p      = PROD_W'(y) * PROD_W'(RECIP_100);
        div100 = p[RECIP_SHIFT-1:0] < RECIP_SHIFT'(RECIP_100);
        q_lo   = p[RECIP_SHIFT+1:RECIP_SHIFT];
        return (y[1:0] == 2'd0) && (!div100 || (q_lo == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = DAYS_SHORT;
            4'd2:                    len = leap ? DAYS_FEB_L : DAYS_FEB;
            default:                 len = DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

[rtl/ccst_in_if.sv]
// interface: input word channel carrying mode and date fields
`timescale 1ns / 1ps
`default_nettype none
interface ccst_in_if;
    import ccst_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [YEAR_W-1:0] in_year;
    logic [MON_W-1:0]  in_month;
    logic [DAY_W-1:0]  in_day;
    logic [HOUR_W-1:0] in_hour;
    logic [MIN_W-1:0]  in_minute;
    logic [SEC_W-1:0]  in_second;

    modport source (
        output valid, mode, in_year, in_month, in_day, in_hour, in_minute, in_second,
        input  ready
    );
    modport sink (
        input  valid, mode, in_year, in_month, in_day, in_hour, in_minute, in_second,
        output ready
    );
endinterface
`default_nettype wire

[rtl/ccst_out_if.sv]
// interface: result word channel carrying current date and compare flags
`timescale 1ns / 1ps
`default_nettype none
interface ccst_out_if;
    import ccst_pkg::*;

    logic              valid;
    logic              ready;
    logic [YEAR_W-1:0] out_year;
    logic [MON_W-1:0]  out_month;
    logic [DAY_W-1:0]  out_day;
    logic [HOUR_W-1:0] out_hour;
    logic [MIN_W-1:0]  out_minute;
    logic [SEC_W-1:0]  out_second;
    logic              is_equal;
    logic              is_later;
    logic              is_earlier;

    modport source (
        output valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
               is_equal, is_later, is_earlier,
        input  ready
    );
    modport sink (
        input  valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
               is_equal, is_later, is_earlier,
        output ready
    );
endinterface
`default_nettype wire

[rtl/ccst_step.sv]
// next-state logic: tick rollover, clamped load and date compare
`timescale 1ns / 1ps
`default_nettype none
module ccst_step (
    input  wire logic [1:0]      i_mode,
    input  wire ccst_pkg::t_date i_cur,
    input  wire ccst_pkg::t_date i_arg,
    output ccst_pkg::t_date      o_next,
    output ccst_pkg::t_flags     o_flags
);
    import ccst_pkg::*;

    t_date             w_load;
    t_date             w_tick;
    logic [YEAR_W-1:0] w_lyear;
    logic [YEAR_W-1:0] w_leap_y;
    logic              w_leap;
    logic [DAY_W-1:0]  w_len;
    logic              w_is_load;

    assign w_is_load = (i_mode == MODE_LOAD);

    // clamped load year and month feed the shared month-length logic
    always_comb begin
        w_lyear = (i_arg.year > MAX_YEAR) ? MAX_YEAR : i_arg.year;
        w_load  = i_arg;
        w_load.year = w_lyear;
        if (i_arg.month == '0) begin
            w_load.month = MON_W'(1);
        end else if (i_arg.month > MONTHS) begin
            w_load.month = MONTHS;
        end
        if (i_arg.hour > LAST_HOUR) begin
            w_load.hour = LAST_HOUR;
        end
        if (i_arg.minute > LAST_MIN) begin
            w_load.minute = LAST_MIN;
        end
        if (i_arg.second > LAST_SEC) begin
            w_load.second = LAST_SEC;
        end
    end

    assign w_leap_y = w_is_load ? w_lyear : i_cur.year;
    assign w_leap   = leap_year(w_leap_y);
    assign w_len    = month_len(w_is_load ? w_load.month : i_cur.month, w_leap);

    always_comb begin
        w_tick = i_cur;
        if (i_cur.second < LAST_SEC) begin
            w_tick.second = i_cur.second + SEC_W'(1);
        end else begin
            w_tick.second = '0;
            if (i_cur.minute < LAST_MIN) begin
                w_tick.minute = i_cur.minute + MIN_W'(1);
            end else begin
                w_tick.minute = '0;
                if (i_cur.hour < LAST_HOUR) begin
                    w_tick.hour = i_cur.hour + HOUR_W'(1);
                end else begin
                    w_tick.hour = '0;
                    if (i_cur.day < w_len) begin
                        w_tick.day = i_cur.day + DAY_W'(1);
                    end else begin
                        w_tick.day = DAY_W'(1);
                        if (i_cur.month < MONTHS) begin
                            w_tick.month = i_cur.month + MON_W'(1);
                        end else begin
                            w_tick.month = MON_W'(1);
                            w_tick.year  = (i_cur.year >= MAX_YEAR) ? '0
                                                                   : i_cur.year + YEAR_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        o_next  = i_cur;
        o_flags = '0;
        case (i_mode)
            MODE_TICK: begin
                o_next = w_tick;
            end
            MODE_LOAD: begin
                o_next = w_load;
                if (i_arg.day == '0) begin
                    o_next.day = DAY_W'(1);
                end else if (i_arg.day > w_len) begin
                    o_next.day = w_len;
                end
            end
            MODE_CMP: begin
                // packed field order makes this a year-first lexicographic compare
                o_flags.is_equal   = (i_cur == i_arg);
                o_flags.is_later   = (i_cur > i_arg);
                o_flags.is_earlier = (i_cur < i_arg);
            end
            default: begin
                o_next = i_cur;
            end
        endcase
    end
endmodule
`default_nettype wire

[rtl/calendar_clock_second_tick_top.sv]
// path: each accepted word passes the input register, then the result register
// throughput: one word per cycle when o_out.ready; the registers decouple sides
// the date register updates as each word leaves the input register
// reset: synchronous active low, date returns to 2000-01-01 00:00:00
// reset empties both registers so no result is pending
`timescale 1ns / 1ps
`default_nettype none
module calendar_clock_second_tick_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ccst_in_if.sink    i_in,
    ccst_out_if.source o_out
);
    import ccst_pkg::*;

    logic       r_in_vld;
    logic [1:0] r_in_mode;
    t_date      r_in_arg;
    t_date      r_date;
    logic       r_out_vld;
    t_date      r_out_date;
    t_flags     r_out_flags;

    t_date      n_date;
    t_flags     n_flags;
    logic       w_adv;
    logic       w_take;

    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign w_take     = i_in.valid && i_in.ready;

    ccst_step u_step (
        .i_mode  (r_in_mode),
        .i_cur   (r_date),
        .i_arg   (r_in_arg),
        .o_next  (n_date),
        .o_flags (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_date    <= RST_DATE;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_date    <= n_date;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_mode       <= i_in.mode;
            r_in_arg.year   <= i_in.in_year;
            r_in_arg.month  <= i_in.in_month;
            r_in_arg.day    <= i_in.in_day;
            r_in_arg.hour   <= i_in.in_hour;
            r_in_arg.minute <= i_in.in_minute;
            r_in_arg.second <= i_in.in_second;
        end
        if (w_adv) begin
            r_out_date  <= n_date;
            r_out_flags <= n_flags;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_year   = r_out_date.year;
    assign o_out.out_month  = r_out_date.month;
    assign o_out.out_day    = r_out_date.day;
    assign o_out.out_hour   = r_out_date.hour;
    assign o_out.out_minute = r_out_date.minute;
    assign o_out.out_second = r_out_date.second;
    assign o_out.is_equal   = r_out_flags.is_equal;
    assign o_out.is_later   = r_out_flags.is_later;
    assign o_out.is_earlier = r_out_flags.is_earlier;
endmodule
`default_nettype wire
